// ===== sv/m68k_pkg.sv =====
package m68k_pkg;

    typedef enum logic [4:0] {
        OP_MOVE  = 5'd0,
        OP_MOVEQ = 5'd1,
        OP_CLR   = 5'd2,
        OP_MOVEA = 5'd3,
        OP_ADD   = 5'd4,
        OP_SUB   = 5'd5,
        OP_CMP   = 5'd6,
        OP_AND   = 5'd7,
        OP_OR    = 5'd8,
        OP_EOR   = 5'd9,
        OP_EXT   = 5'd10,
        OP_SWAP  = 5'd11,
        OP_BTST  = 5'd12,
        OP_BCHG  = 5'd13,
        OP_BCLR  = 5'd14,
        OP_BSET  = 5'd15,
        OP_SCC   = 5'd16,
        OP_CHK   = 5'd17,
        OP_TRAPV = 5'd18
    } t_op;

    typedef enum logic [3:0] {
        CC_T  = 4'h0,
        CC_F  = 4'h1,
        CC_HI = 4'h2,
        CC_LS = 4'h3,
        CC_CC = 4'h4,
        CC_CS = 4'h5,
        CC_NE = 4'h6,
        CC_EQ = 4'h7,
        CC_VC = 4'h8,
        CC_VS = 4'h9,
        CC_PL = 4'ha,
        CC_MI = 4'hb,
        CC_GE = 4'hc,
        CC_LT = 4'hd,
        CC_GT = 4'he,
        CC_LE = 4'hf
    } t_cond;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    localparam logic [1:0] TRAP_NONE  = 2'd0;
    localparam logic [1:0] TRAP_CHK   = 2'd1;
    localparam logic [1:0] TRAP_TRAPV = 2'd2;

    // bit positions in the flag word
    localparam int FLAG_X = 4;
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    localparam logic [31:0] MASK_BYTE  = 32'h0000_00ff;
    localparam logic [31:0] MASK_WORD  = 32'h0000_ffff;
    localparam logic [31:0] MASK_LONG  = 32'hffff_ffff;

    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  size;
        logic [31:0] src_value;
        logic [31:0] dst_value;
        logic [7:0]  bit_number;
        logic        dst_is_data_reg;
        logic [3:0]  cond_code;
    } t_alu_in;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_back;
        logic [4:0]  flags_out;
        logic [1:0]  trap_code;
    } t_alu_out;

endpackage

// ===== sv/m68k_alu_and_condition_flags.sv =====
// Pipeline: an accepted input beat is held in the input register, then moves
//   into the result register, where its result beat is offered.
// Throughput: one operation per clock while the result side is ready; the flag
//   register closes its loop through the execute logic, so dependent items stream.
// Reset: synchronous, active low; clears both stage valids and all flags.
module m68k_alu_and_condition_flags
    import m68k_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_alu_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_alu_out o_data
);

    // Input stage holds one operation; result stage holds one finished beat.
    logic     r_in_valid;
    t_alu_in  r_in;
    logic     r_out_valid;
    t_alu_out r_out;
    logic [4:0] r_ccr;

    t_alu_out exec_result;
    logic     advance;
    logic     out_free;

    // Execute against the current flags; the flags update when the item
    // moves into the result stage, so the next item sees them at once.
    m68k_exec u_exec (
        .i_item   (r_in),
        .i_flags  (r_ccr),
        .o_result (exec_result)
    );

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    // Take a new beat when the input stage is empty or drains this cycle.
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ccr       <= 5'd0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_ccr <= exec_result.flags_out;
            end
        end
    end

    // Payload registers: load on the handshake, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_out <= exec_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== sv/m68k_cond.sv =====
module m68k_cond
    import m68k_pkg::*;
(
    input  logic [4:0] i_flags,
    input  logic [3:0] i_cond_code,
    output logic       o_holds
);

    logic c, z, n, v;

    assign c = i_flags[FLAG_C];
    assign z = i_flags[FLAG_Z];
    assign n = i_flags[FLAG_N];
    assign v = i_flags[FLAG_V];

    always_comb begin
        case (t_cond'(i_cond_code))
            CC_T:    o_holds = 1'b1;
            CC_F:    o_holds = 1'b0;
            CC_HI:   o_holds = !c && !z;
            CC_LS:   o_holds = c || z;
            CC_CC:   o_holds = !c;
            CC_CS:   o_holds = c;
            CC_NE:   o_holds = !z;
            CC_EQ:   o_holds = z;
            CC_VC:   o_holds = !v;
            CC_VS:   o_holds = v;
            CC_PL:   o_holds = !n;
            CC_MI:   o_holds = n;
            CC_GE:   o_holds = (n == v);
            CC_LT:   o_holds = (n != v);
            CC_GT:   o_holds = !z && (n == v);
            default: o_holds = z || (n != v);
        endcase
    end

endmodule

// ===== sv/m68k_exec.sv =====
module m68k_exec
    import m68k_pkg::*;
(
    input  t_alu_in    i_item,
    input  logic [4:0] i_flags,
    output t_alu_out   o_result
);

    logic        cond_holds;
    logic [31:0] size_mask;
    logic [31:0] s_val;
    logic [31:0] d_val;
    logic [32:0] sum;
    logic [31:0] add_res;
    logic [31:0] diff;
    logic        add_c;
    logic [31:0] bit_wmask;
    logic [4:0]  bit_idx;
    logic [31:0] bit_sel;
    logic [31:0] bit_dst;
    logic signed [15:0] chk_val;
    logic signed [15:0] chk_bound;

    m68k_cond u_cond (
        .i_flags     (i_flags),
        .i_cond_code (i_item.cond_code),
        .o_holds     (cond_holds)
    );

    function automatic logic size_msb(input logic [1:0] sz, input logic [31:0] val);
        case (sz)
            SIZE_BYTE: size_msb = val[7];
            SIZE_WORD: size_msb = val[15];
            default:   size_msb = val[31];
        endcase
    endfunction

    // N, Z, V, C replaced; X follows C only when with_x is set
    function automatic logic [4:0] put_nzvc(input logic [4:0] f, input logic n,
                                            input logic z, input logic v,
                                            input logic c, input logic with_x);
        logic [4:0] r;
        r         = 5'd0;
        r[FLAG_X] = with_x ? c : f[FLAG_X];
        r[FLAG_N] = n;
        r[FLAG_Z] = z;
        r[FLAG_V] = v;
        r[FLAG_C] = c;
        put_nzvc  = r;
    endfunction

    always_comb begin
        case (i_item.size)
            SIZE_BYTE: size_mask = MASK_BYTE;
            SIZE_WORD: size_mask = MASK_WORD;
            default:   size_mask = MASK_LONG;
        endcase
    end

    assign s_val   = i_item.src_value & size_mask;
    assign d_val   = i_item.dst_value & size_mask;
    assign sum     = {1'b0, s_val} + {1'b0, d_val};
    assign add_res = sum[31:0] & size_mask;
    assign diff    = (d_val - s_val) & size_mask;

    always_comb begin
        case (i_item.size)
            SIZE_BYTE: add_c = sum[8];
            SIZE_WORD: add_c = sum[16];
            default:   add_c = sum[32];
        endcase
    end

    assign bit_idx   = i_item.dst_is_data_reg ? i_item.bit_number[4:0]
                                              : {2'b00, i_item.bit_number[2:0]};
    assign bit_wmask = i_item.dst_is_data_reg ? MASK_LONG : MASK_BYTE;
    assign bit_sel   = 32'd1 << bit_idx;
    assign bit_dst   = i_item.dst_value & bit_wmask;

    assign chk_val   = $signed(i_item.dst_value[15:0]);
    assign chk_bound = $signed(i_item.src_value[15:0]);

    always_comb begin
        logic [31:0] res;
        logic [4:0]  f;
        logic        wr;
        logic [1:0]  trap;
        res  = 32'd0;
        f    = i_flags;
        wr   = 1'b0;
        trap = TRAP_NONE;
        case (t_op'(i_item.op))
            OP_MOVE, OP_AND, OP_OR, OP_EOR: begin
                case (t_op'(i_item.op))
                    OP_MOVE: res = s_val;
                    OP_AND:  res = s_val & d_val;
                    OP_OR:   res = s_val | d_val;
                    default: res = s_val ^ d_val;
                endcase
                f  = put_nzvc(f, size_msb(i_item.size, res), res == 32'd0,
                              1'b0, 1'b0, 1'b0);
                wr = 1'b1;
            end
            OP_MOVEQ: begin
                res = {{24{i_item.src_value[7]}}, i_item.src_value[7:0]};
                f   = put_nzvc(f, res[31], res == 32'd0, 1'b0, 1'b0, 1'b0);
                wr  = 1'b1;
            end
            OP_CLR: begin
                f  = put_nzvc(f, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                wr = 1'b1;
            end
            OP_MOVEA: begin
                res = i_item.size[1] ? i_item.src_value
                                     : {{16{i_item.src_value[15]}}, i_item.src_value[15:0]};
                wr  = 1'b1;
            end
            OP_ADD: begin
                res = add_res;
                f   = put_nzvc(f, size_msb(i_item.size, add_res), add_res == 32'd0,
                               size_msb(i_item.size, ~(s_val ^ d_val) & (d_val ^ add_res)),
                               add_c, 1'b1);
                wr  = 1'b1;
            end
            OP_SUB, OP_CMP: begin
                f = put_nzvc(f, size_msb(i_item.size, diff), diff == 32'd0,
                             size_msb(i_item.size, (d_val ^ s_val) & (d_val ^ diff)),
                             s_val > d_val, t_op'(i_item.op) == OP_SUB);
                if (t_op'(i_item.op) == OP_SUB) begin
                    res = diff;
                    wr  = 1'b1;
                end
            end
            OP_EXT: begin
                if (i_item.size[1]) begin
                    res = {{16{i_item.dst_value[15]}}, i_item.dst_value[15:0]};
                    f   = put_nzvc(f, res[31], res == 32'd0, 1'b0, 1'b0, 1'b0);
                end else begin
                    res = {16'd0, {8{i_item.dst_value[7]}}, i_item.dst_value[7:0]};
                    f   = put_nzvc(f, res[15], res == 32'd0, 1'b0, 1'b0, 1'b0);
                end
                wr = 1'b1;
            end
            OP_SWAP: begin
                res = {i_item.dst_value[15:0], i_item.dst_value[31:16]};
                f   = put_nzvc(f, res[31], res == 32'd0, 1'b0, 1'b0, 1'b0);
                wr  = 1'b1;
            end
            OP_BTST, OP_BCHG, OP_BCLR, OP_BSET: begin
                // Z reflects the bit before it changes
                f[FLAG_Z] = ~|(bit_dst & bit_sel);
                case (t_op'(i_item.op))
                    OP_BCHG: begin res = bit_dst ^ bit_sel;  wr = 1'b1; end
                    OP_BCLR: begin res = bit_dst & ~bit_sel; wr = 1'b1; end
                    OP_BSET: begin res = bit_dst | bit_sel;  wr = 1'b1; end
                    default: res = 32'd0;
                endcase
                res = res & bit_wmask;
            end
            OP_SCC: begin
                res = cond_holds ? MASK_BYTE : 32'd0;
                wr  = 1'b1;
            end
            OP_CHK: begin
                if (chk_val < 0) begin
                    f[FLAG_N] = 1'b1;
                    trap      = TRAP_CHK;
                end else if (chk_val > chk_bound) begin
                    f[FLAG_N] = 1'b0;
                    trap      = TRAP_CHK;
                end
            end
            OP_TRAPV: begin
                if (i_flags[FLAG_V]) begin
                    trap = TRAP_TRAPV;
                end
            end
            default: begin
                res = 32'd0;
            end
        endcase
        o_result.result_value = res;
        o_result.write_back   = wr;
        o_result.flags_out    = f;
        o_result.trap_code    = trap;
    end

endmodule

// ===== dv/m68k_alu_and_condition_flags_tb.sv =====
module m68k_alu_and_condition_flags_tb
    import m68k_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_ODD  = 2'd3;   // decodes as long

    // Mirror of the execute stage: keeps its own copy of the condition codes
    // and queues the result beat that each accepted operation must produce.
    class alu_result_board;
        logic [4:0] ccr;
        t_alu_out   expected_results[$];
        int         mismatches;

        function new();
            ccr        = '0;
            mismatches = 0;
        endfunction

        // Replace N, Z, V, C; X follows C for add and sub, else it is held.
        function logic [4:0] nzvc(logic [4:0] f, logic n, logic z, logic v, logic c,
                                  logic with_x);
            logic [4:0] g;
            g         = '0;
            g[FLAG_X] = with_x ? c : f[FLAG_X];
            g[FLAG_N] = n;
            g[FLAG_Z] = z;
            g[FLAG_V] = v;
            g[FLAG_C] = c;
            return g;
        endfunction

        function t_alu_out execute_op(t_alu_in x);
            logic [31:0]        m, msb, s, d, res, diff, wm, bd, bitmask;
            logic [32:0]        sum;
            logic [4:0]         f;
            logic               wr, holds, fn, fz, fv, fc;
            logic [1:0]         trap;
            logic signed [15:0] val, bound;
            t_alu_out           o;
            case (x.size)
                SIZE_BYTE: m = MASK_BYTE;
                SIZE_WORD: m = MASK_WORD;
                default:   m = MASK_LONG;
            endcase
            msb  = m & ~(m >> 1);
            s    = x.src_value & m;
            d    = x.dst_value & m;
            f    = ccr;
            res  = '0;
            wr   = 1'b0;
            trap = TRAP_NONE;
            case (x.op)
                OP_MOVE, OP_AND, OP_OR, OP_EOR: begin
                    case (x.op)
                        OP_MOVE: res = s;
                        OP_AND:  res = s & d;
                        OP_OR:   res = s | d;
                        default: res = s ^ d;
                    endcase
                    f  = nzvc(f, |(res & msb), res == 0, 1'b0, 1'b0, 1'b0);
                    wr = 1'b1;
                end
                OP_MOVEQ: begin
                    res = {{24{x.src_value[7]}}, x.src_value[7:0]};
                    f   = nzvc(f, res[31], res == 0, 1'b0, 1'b0, 1'b0);
                    wr  = 1'b1;
                end
                OP_CLR: begin
                    f  = nzvc(f, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                    wr = 1'b1;
                end
                OP_MOVEA: begin
                    res = x.size[1] ? x.src_value
                                    : {{16{x.src_value[15]}}, x.src_value[15:0]};
                    wr  = 1'b1;
                end
                OP_ADD: begin
                    sum = {1'b0, s} + {1'b0, d};
                    res = sum[31:0] & m;
                    fc  = sum > {1'b0, m};
                    fv  = |(~(s ^ d) & (d ^ res) & msb);
                    f   = nzvc(f, |(res & msb), res == 0, fv, fc, 1'b1);
                    wr  = 1'b1;
                end
                OP_SUB, OP_CMP: begin
                    diff = (d - s) & m;
                    fc   = s > d;
                    fv   = |((d ^ s) & (d ^ diff) & msb);
                    f    = nzvc(f, |(diff & msb), diff == 0, fv, fc, x.op == OP_SUB);
                    if (x.op == OP_SUB) begin
                        res = diff;
                        wr  = 1'b1;
                    end
                end
                OP_EXT: begin
                    if (x.size[1]) begin
                        res = {{16{x.dst_value[15]}}, x.dst_value[15:0]};
                        fn  = res[31];
                    end else begin
                        res = {16'h0, {8{x.dst_value[7]}}, x.dst_value[7:0]};
                        fn  = res[15];
                    end
                    f  = nzvc(f, fn, res == 0, 1'b0, 1'b0, 1'b0);
                    wr = 1'b1;
                end
                OP_SWAP: begin
                    res = {x.dst_value[15:0], x.dst_value[31:16]};
                    f   = nzvc(f, res[31], res == 0, 1'b0, 1'b0, 1'b0);
                    wr  = 1'b1;
                end
                OP_BTST, OP_BCHG, OP_BCLR, OP_BSET: begin
                    // Data register: modulo 32 on the long; memory: modulo 8 on a byte.
                    wm        = x.dst_is_data_reg ? MASK_LONG : MASK_BYTE;
                    bitmask   = x.dst_is_data_reg ? (32'd1 << x.bit_number[4:0])
                                                  : (32'd1 << x.bit_number[2:0]);
                    bd        = x.dst_value & wm;
                    f[FLAG_Z] = ~|(bd & bitmask);
                    case (x.op)
                        OP_BCHG: res = bd ^ bitmask;
                        OP_BCLR: res = bd & ~bitmask;
                        OP_BSET: res = bd | bitmask;
                        default: res = '0;
                    endcase
                    res = res & wm;
                    wr  = x.op != OP_BTST;
                end
                OP_SCC: begin
                    fc = f[FLAG_C];
                    fz = f[FLAG_Z];
                    fn = f[FLAG_N];
                    fv = f[FLAG_V];
                    case (x.cond_code)
                        CC_T:    holds = 1'b1;
                        CC_F:    holds = 1'b0;
                        CC_HI:   holds = !fc && !fz;
                        CC_LS:   holds = fc || fz;
                        CC_CC:   holds = !fc;
                        CC_CS:   holds = fc;
                        CC_NE:   holds = !fz;
                        CC_EQ:   holds = fz;
                        CC_VC:   holds = !fv;
                        CC_VS:   holds = fv;
                        CC_PL:   holds = !fn;
                        CC_MI:   holds = fn;
                        CC_GE:   holds = fn == fv;
                        CC_LT:   holds = fn != fv;
                        CC_GT:   holds = !fz && (fn == fv);
                        default: holds = fz || (fn != fv);
                    endcase
                    res = holds ? 32'h0000_00ff : 32'h0;
                    wr  = 1'b1;
                end
                OP_CHK: begin
                    // signed word compare against zero and the bound
                    val   = x.dst_value[15:0];
                    bound = x.src_value[15:0];
                    if (val < 0) begin
                        f[FLAG_N] = 1'b1;
                        trap      = TRAP_CHK;
                    end else if (val > bound) begin
                        f[FLAG_N] = 1'b0;
                        trap      = TRAP_CHK;
                    end
                end
                OP_TRAPV: begin
                    if (f[FLAG_V]) trap = TRAP_TRAPV;
                end
                default: ;
            endcase
            ccr            = f;
            o.result_value = res;
            o.write_back   = wr;
            o.flags_out    = f;
            o.trap_code    = trap;
            return o;
        endfunction

        function void note_operation(t_alu_in x);
            expected_results.push_back(execute_op(x));
        endfunction

        function void check_result(t_alu_out got);
            t_alu_out want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: value %h wb %b flags %b trap %0d",
                             got.result_value, got.write_back, got.flags_out,
                             got.trap_code);
                return;
            end
            want = expected_results.pop_front();
            if (got.result_value !== want.result_value || got.write_back !== want.write_back
                || got.flags_out !== want.flags_out || got.trap_code !== want.trap_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: value %h/%h wb %b/%b flags %b/%b trap %0d/%0d (exp/act)",
                             want.result_value, got.result_value,
                             want.write_back, got.write_back,
                             want.flags_out, got.flags_out,
                             want.trap_code, got.trap_code);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_alu_in  i_data;
    logic     o_valid;
    logic     i_ready;
    t_alu_out o_data;

    alu_result_board board;

    // Percentage chance of an idle burst on each side; zero turns idling off.
    int idle_pct;

    m68k_alu_and_condition_flags i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Sample both handshakes on the edge; operands enter the predictor in
    // acceptance order, which is the order the flag register sees them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) board.note_operation(i_data);
            if (o_valid && i_ready) board.check_result(o_data);
        end
    end

    // Result side: hold ready low for random bursts.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic t_alu_in mk(logic [4:0] op, logic [1:0] size, logic [31:0] src,
                                   logic [31:0] dst, logic [7:0] bitn, logic dreg,
                                   logic [3:0] cc);
        t_alu_in x;
        x.op              = op;
        x.size            = size;
        x.src_value       = src;
        x.dst_value       = dst;
        x.bit_number      = bitn;
        x.dst_is_data_reg = dreg;
        x.cond_code       = cc;
        return x;
    endfunction

    // Bias operands toward sign, carry and zero boundaries.
    function automatic logic [31:0] rand_operand();
        logic [31:0] corners [8];
        corners = '{32'h0, 32'hffff_ffff, 32'h0000_0080, 32'h0000_007f,
                    32'h0000_8000, 32'h0000_7fff, 32'h8000_0000, 32'h7fff_ffff};
        case ($urandom_range(0, 7))
            0, 1:    return corners[$urandom_range(0, 7)];
            2:       return $urandom_range(0, 3);
            3:       return corners[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_alu_in rand_item();
        logic [4:0] op;
        logic [1:0] size;
        op   = ($urandom_range(0, 99) < 92) ? 5'($urandom_range(0, 18))
                                            : 5'($urandom_range(19, 31));
        size = ($urandom_range(0, 9) == 0) ? SIZE_ODD : 2'($urandom_range(0, 2));
        return mk(op, size, rand_operand(), rand_operand(), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endfunction

    // Present one beat, hold it until accepted, then maybe idle a burst.
    task automatic send_beat(input t_alu_in x);
        i_valid <= 1'b1;
        i_data  <= x;
        do @(posedge i_clk); while (!o_ready);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_beat(rand_item());
    endtask

    initial begin
        board    = new();
        idle_pct = 15;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_data   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners: zero and sign results, carry and overflow, the
        // bit-number wrap on both destinations, every chk outcome, trapv.
        send_beat(mk(OP_MOVE,  SIZE_BYTE, 32'h0000_0100, 32'hffff_ffff, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_MOVE,  SIZE_WORD, 32'h0000_8000, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_MOVEQ, SIZE_LONG, 32'hffff_ff80, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_CLR,   SIZE_LONG, 32'h0, 32'hffff_ffff, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_MOVEA, SIZE_WORD, 32'h0000_8000, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_MOVEA, SIZE_BYTE, 32'h1234_ff00, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_ADD,   SIZE_BYTE, 32'h0000_0001, 32'h0000_007f, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_ADD,   SIZE_BYTE, 32'h0000_0001, 32'h0000_00ff, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_SCC,   SIZE_BYTE, 32'h0, 32'h0, 8'h00, 1'b0, CC_CS));
        send_beat(mk(OP_SUB,   SIZE_WORD, 32'h0000_0001, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_SUB,   SIZE_LONG, 32'h0000_0001, 32'h8000_0000, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_TRAPV, SIZE_LONG, 32'h0, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_CMP,   SIZE_LONG, 32'hdead_beef, 32'hdead_beef, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_AND,   SIZE_LONG, 32'hf0f0_f0f0, 32'h0f0f_0f0f, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_OR,    SIZE_WORD, 32'h0000_8001, 32'h0000_0100, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_EOR,   SIZE_LONG, 32'hffff_ffff, 32'h7fff_ffff, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_EXT,   SIZE_WORD, 32'h0, 32'h1234_5680, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_EXT,   SIZE_LONG, 32'h0, 32'h0000_8000, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_EXT,   SIZE_BYTE, 32'h0, 32'hffff_ff00, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_SWAP,  SIZE_LONG, 32'h0, 32'h0000_8000, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_SWAP,  SIZE_LONG, 32'h0, 32'h0, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_BTST,  SIZE_LONG, 32'h0, 32'h8000_0000, 8'hff, 1'b1, CC_T));
        send_beat(mk(OP_BCHG,  SIZE_BYTE, 32'h0, 32'hffff_ff7f, 8'hff, 1'b0, CC_T));
        send_beat(mk(OP_BCLR,  SIZE_LONG, 32'h0, 32'hffff_ffff, 8'h00, 1'b1, CC_T));
        send_beat(mk(OP_BSET,  SIZE_BYTE, 32'h0, 32'h0, 8'h0b, 1'b0, CC_F));
        send_beat(mk(OP_CHK,   SIZE_WORD, 32'h0000_0064, 32'h0000_ffff, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_CHK,   SIZE_WORD, 32'h0000_0064, 32'h0000_00c8, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_CHK,   SIZE_WORD, 32'hffff_8000, 32'h0000_7fff, 8'h00, 1'b0, CC_T));
        send_beat(mk(OP_CHK,   SIZE_WORD, 32'h0000_0064, 32'h0000_0032, 8'h00, 1'b0, CC_T));
        send_beat(mk(5'd31,    SIZE_ODD,  32'hffff_ffff, 32'hffff_ffff, 8'hff, 1'b1, CC_LE));

        send_random(300);

        // Starve the block completely once, then resume with heavier idling.
        i_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        idle_pct = 35;
        send_random(300);

        // Closing stretch at full rate on both sides.
        idle_pct = 0;
        send_random(150);
        i_valid <= 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
